// File: rtl/core/ogru_pkg.sv
// Package for the occupancy grid ray update block.
// Holds operation codes, register indexes and shared types. No dependencies.
package ogru_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_HIT   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] REG_HIT_INC   = 3'd0;
    localparam logic [2:0] REG_FREE_DEC  = 3'd1;
    localparam logic [2:0] REG_OCC_THR   = 3'd2;
    localparam logic [2:0] REG_CLR_THR   = 3'd3;
    localparam logic [2:0] REG_MIN_SCORE = 3'd4;
    localparam logic [2:0] REG_MAX_SCORE = 3'd5;

    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_FREE     = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;

    typedef struct packed {
        logic [7:0]         hit_inc;
        logic [7:0]         free_dec;
        logic signed [15:0] occ_thr;
        logic signed [15:0] clr_thr;
        logic signed [15:0] min_score;
        logic signed [15:0] max_score;
    } t_cfg;

    // cell word: {visited, confirmed, score}
    typedef struct packed {
        logic               visited;
        logic               confirmed;
        logic signed [15:0] score;
    } t_cell;

endpackage

// File: rtl/core/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block.
// Depends on ogru_pkg, ogru_ram and ogru_cell_alu.
//
// One item at a time: start is taken when busy is low, and exactly one result
// word follows on o_valid for a single cycle; the receiver cannot stall it.
// After reset a clearing pass runs over the cell and stamp memories with busy
// high. A ray is walked cell by cell, with a read, a wait and a write per cell
// through one memory port pair and one shared update unit; a hit ray first
// passes a stamp check (stamp read, wait, check), and a duplicate hit then
// skips the walk and only reads its end cell. A read goes through a read wait
// and an output state; a begin scan or a ray off the grid goes straight to the
// done state. A begin scan that wraps the stamp first runs a clearing pass of
// the stamp memory. busy falls with the result word, so the next item can be
// taken at the edge that ends it.
module occupancy_grid_ray_update #(
    parameter int GRID_X     = 256,
    parameter int GRID_Y     = 256,
    parameter int STAMP_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_start_x,
    input  logic [7:0]  i_start_y,
    input  logic [7:0]  i_end_x,
    input  logic [7:0]  i_end_y,
    output logic        o_valid,
    output logic        o_newly_occupied,
    output logic        o_duplicate_skipped,
    output logic [1:0]  o_cell_state,
    output logic [8:0]  o_cells_touched
);

    localparam int NCELLS = GRID_X * GRID_Y;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(GRID_X) + 1;
    localparam int YW     = $clog2(GRID_Y) + 1;
    localparam int CW     = 18;
    localparam int EW     = ((XW > YW) ? XW : YW) + 3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_STAMP_RD, S_STAMP_WAIT, S_STAMP_CHK,
        S_CELL_RD, S_CELL_WAIT, S_CELL_WR, S_READ_WAIT, S_READ_OUT, S_DONE
    } t_state;

    t_state             r_state;
    ogru_pkg::t_cfg     r_cfg;
    logic [1:0]         r_op;
    logic [XW-1:0]      r_x, r_x1;
    logic [YW-1:0]      r_y, r_y1;
    logic               r_sx, r_sy;
    logic signed [EW-1:0] r_dx, r_dy, r_err;
    logic [8:0]         r_count;
    logic               r_dup;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clr_cells;
    logic [STAMP_BITS-1:0] r_stamp;

    logic [AW-1:0]      addr;
    logic [AW-1:0]      end_addr;
    logic               cell_we;
    logic [CW-1:0]      cell_wdata;
    logic [CW-1:0]      cell_rdata;
    logic               stamp_we;
    logic [AW-1:0]      stamp_waddr;
    logic [STAMP_BITS-1:0] stamp_wdata;
    logic [AW-1:0]      stamp_raddr;
    logic [STAMP_BITS-1:0] stamp_rdata;
    ogru_pkg::t_cell    cell_rd, cell_new;
    logic               alu_newly;
    logic               last;
    logic signed [EW-1:0] e2, n_err;
    logic               on_s, on_e;
    logic [STAMP_BITS-1:0] n_stamp;

    assign addr     = AW'(r_x) + AW'(r_y) * AW'(GRID_X);
    assign end_addr = AW'(r_x1) + AW'(r_y1) * AW'(GRID_X);
    assign last     = (r_x == r_x1) && (r_y == r_y1);
    assign cell_rd  = ogru_pkg::t_cell'(cell_rdata);
    assign busy     = (r_state != S_IDLE);
    assign on_s     = (int'(i_start_x) < GRID_X) && (int'(i_start_y) < GRID_Y);
    assign on_e     = (int'(i_end_x) < GRID_X) && (int'(i_end_y) < GRID_Y);
    assign n_stamp  = r_stamp + 1'b1;

    always_comb begin
        e2    = r_err <<< 1;
        n_err = r_err;
        if (e2 >= r_dy) begin
            n_err = n_err + r_dy;
        end
        if (e2 <= r_dx) begin
            n_err = n_err + r_dx;
        end
    end

    always_comb begin
        cell_we     = 1'b0;
        cell_wdata  = cell_new;
        stamp_we    = 1'b0;
        stamp_waddr = end_addr;
        stamp_wdata = r_stamp;
        stamp_raddr = end_addr;
        if (r_state == S_CLEAR) begin
            cell_we     = r_clr_cells;
            cell_wdata  = '0;
            stamp_we    = 1'b1;
            stamp_waddr = r_clr_addr;
            stamp_wdata = '0;
        end else if (r_state == S_CELL_WR) begin
            cell_we = 1'b1;
        end else if (r_state == S_STAMP_CHK && stamp_rdata != r_stamp) begin
            stamp_we = 1'b1;
        end
    end

    ogru_ram #(.WIDTH(CW), .DEPTH(NCELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr ((r_state == S_CLEAR) ? r_clr_addr : addr),
        .i_wdata (cell_wdata),
        .i_raddr (addr),
        .o_rdata (cell_rdata)
    );

    ogru_ram #(.WIDTH(STAMP_BITS), .DEPTH(NCELLS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (stamp_raddr),
        .o_rdata (stamp_rdata)
    );

    ogru_cell_alu u_alu (
        .i_cfg     (r_cfg),
        .i_cell    (cell_rd),
        .i_hit_end ((r_op == ogru_pkg::OP_HIT) && last),
        .o_cell    (cell_new),
        .o_newly   (alu_newly)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_CLEAR;
            r_clr_addr          <= '0;
            r_clr_cells         <= 1'b1;
            r_stamp             <= '0;
            r_cfg.hit_inc       <= 8'd2;
            r_cfg.free_dec      <= 8'd1;
            r_cfg.occ_thr       <= 16'sd4;
            r_cfg.clr_thr       <= 16'sd0;
            r_cfg.min_score     <= -16'sd16;
            r_cfg.max_score     <= 16'sd16;
            o_valid             <= 1'b0;
            o_newly_occupied    <= 1'b0;
            o_duplicate_skipped <= 1'b0;
            o_cell_state        <= ogru_pkg::ST_UNKNOWN;
            o_cells_touched     <= '0;
        end else begin
            o_valid <= ((r_state == S_CELL_WR) && last) || (r_state == S_READ_OUT)
                       || (r_state == S_DONE);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ogru_pkg::REG_HIT_INC:   r_cfg.hit_inc   <= i_cfg_data[7:0];
                    ogru_pkg::REG_FREE_DEC:  r_cfg.free_dec  <= i_cfg_data[7:0];
                    ogru_pkg::REG_OCC_THR:   r_cfg.occ_thr   <= i_cfg_data;
                    ogru_pkg::REG_CLR_THR:   r_cfg.clr_thr   <= i_cfg_data;
                    ogru_pkg::REG_MIN_SCORE: r_cfg.min_score <= i_cfg_data;
                    ogru_pkg::REG_MAX_SCORE: r_cfg.max_score <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(NCELLS - 1)) begin
                        r_clr_cells <= 1'b0;
                        r_state     <= r_clr_cells ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_op;
                        r_x     <= XW'(i_start_x);
                        r_y     <= YW'(i_start_y);
                        r_x1    <= (i_op == ogru_pkg::OP_READ) ? XW'(i_start_x)
                                                               : XW'(i_end_x);
                        r_y1    <= (i_op == ogru_pkg::OP_READ) ? YW'(i_start_y)
                                                               : YW'(i_end_y);
                        r_sx    <= i_start_x < i_end_x;
                        r_sy    <= i_start_y < i_end_y;
                        r_dx    <= (i_end_x > i_start_x) ? EW'(i_end_x - i_start_x)
                                                         : EW'(i_start_x - i_end_x);
                        r_dy    <= (i_end_y > i_start_y) ? -EW'(i_end_y - i_start_y)
                                                         : -EW'(i_start_y - i_end_y);
                        r_err   <= ((i_end_x > i_start_x) ? EW'(i_end_x - i_start_x)
                                                          : EW'(i_start_x - i_end_x))
                                 - ((i_end_y > i_start_y) ? EW'(i_end_y - i_start_y)
                                                          : EW'(i_start_y - i_end_y));
                        r_count <= '0;
                        r_dup   <= 1'b0;
                        case (i_op)
                            ogru_pkg::OP_BEGIN: begin
                                if (n_stamp == '0) begin
                                    r_stamp    <= STAMP_BITS'(1);
                                    r_clr_addr <= '0;
                                    r_state    <= S_CLEAR;
                                end else begin
                                    r_stamp <= n_stamp;
                                    r_state <= S_DONE;
                                end
                            end
                            ogru_pkg::OP_READ: begin
                                r_state <= on_s ? S_READ_WAIT : S_DONE;
                            end
                            ogru_pkg::OP_HIT: begin
                                r_state <= (on_s && on_e) ? S_STAMP_RD : S_DONE;
                            end
                            default: begin
                                r_state <= (on_s && on_e) ? S_CELL_RD : S_DONE;
                            end
                        endcase
                    end
                end
                S_STAMP_RD:   r_state <= S_STAMP_WAIT;
                S_STAMP_WAIT: r_state <= S_STAMP_CHK;
                S_STAMP_CHK: begin
                    if (stamp_rdata == r_stamp) begin
                        r_dup   <= 1'b1;
                        r_x     <= r_x1;
                        r_y     <= r_y1;
                        r_state <= S_READ_WAIT;
                    end else begin
                        r_state <= S_CELL_RD;
                    end
                end
                S_CELL_RD:   r_state <= S_CELL_WAIT;
                S_CELL_WAIT: r_state <= S_CELL_WR;
                S_CELL_WR: begin
                    if (r_count != 9'd511) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (last) begin
                        o_newly_occupied <= alu_newly;
                        o_duplicate_skipped <= 1'b0;
                        o_cell_state     <= cell_new.confirmed ? ogru_pkg::ST_OCCUPIED
                                                               : ogru_pkg::ST_FREE;
                        o_cells_touched  <= (r_count != 9'd511) ? r_count + 1'b1 : r_count;
                        r_state          <= S_IDLE;
                    end else begin
                        r_err <= n_err;
                        if (e2 >= r_dy) begin
                            r_x <= r_sx ? r_x + 1'b1 : r_x - 1'b1;
                        end
                        if (e2 <= r_dx) begin
                            r_y <= r_sy ? r_y + 1'b1 : r_y - 1'b1;
                        end
                        r_state <= S_CELL_RD;
                    end
                end
                S_READ_WAIT: r_state <= S_READ_OUT;
                S_READ_OUT: begin
                    o_newly_occupied    <= 1'b0;
                    o_duplicate_skipped <= r_dup;
                    o_cell_state        <= !cell_rd.visited ? ogru_pkg::ST_UNKNOWN :
                                           cell_rd.confirmed ? ogru_pkg::ST_OCCUPIED
                                                             : ogru_pkg::ST_FREE;
                    o_cells_touched     <= '0;
                    r_state             <= S_IDLE;
                end
                S_DONE: begin
                    o_newly_occupied    <= 1'b0;
                    o_duplicate_skipped <= 1'b0;
                    o_cell_state        <= ogru_pkg::ST_UNKNOWN;
                    o_cells_touched     <= '0;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/ogru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ogru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/ogru_cell_alu.sv
// Shared cell update unit: saturating score add or subtract and mark update.
// Depends on ogru_pkg.
module ogru_cell_alu (
    input  ogru_pkg::t_cfg  i_cfg,
    input  ogru_pkg::t_cell i_cell,
    input  logic            i_hit_end,
    output ogru_pkg::t_cell o_cell,
    output logic            o_newly
);

    logic signed [17:0] sum;
    logic signed [15:0] clamped;
    logic               conf;
    logic               old_occ;

    always_comb begin
        if (i_hit_end) begin
            sum = 18'(i_cell.score) + $signed({10'd0, i_cfg.hit_inc});
        end else begin
            sum = 18'(i_cell.score) - $signed({10'd0, i_cfg.free_dec});
        end
        if (sum < 18'(i_cfg.min_score)) begin
            clamped = i_cfg.min_score;
        end else if (sum > 18'(i_cfg.max_score)) begin
            clamped = i_cfg.max_score;
        end else begin
            clamped = sum[15:0];
        end
        old_occ = i_cell.visited & i_cell.confirmed;
        if (i_hit_end) begin
            conf = i_cell.confirmed | (clamped >= i_cfg.occ_thr);
        end else begin
            conf = i_cell.confirmed & ~(clamped <= i_cfg.clr_thr);
        end
        o_cell.visited   = 1'b1;
        o_cell.confirmed = conf;
        o_cell.score     = clamped;
        o_newly          = i_hit_end & ~old_occ & conf;
    end

endmodule

// File: tb/sv/ogru_ray_checker.sv
`timescale 1ns / 1ps
// Checker for the occupancy grid ray update block: keeps its own cell grid,
// predicts every result word and compares it. Depends on ogru_pkg.
module ogru_ray_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_start_x,
    input  logic [7:0]  i_start_y,
    input  logic [7:0]  i_end_x,
    input  logic [7:0]  i_end_y,
    input  logic        i_valid,
    input  logic        i_newly_occupied,
    input  logic        i_duplicate_skipped,
    input  logic [1:0]  i_cell_state,
    input  logic [8:0]  i_cells_touched,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic       newly;
        logic       dup;
        logic [1:0] state;
        logic [8:0] touched;
    } t_ray_word;

    t_ray_word          words_due[$];
    logic signed [15:0] grid_score [65536];
    bit                 grid_visited [65536];
    bit                 grid_confirmed [65536];
    logic [7:0]         grid_stamp [65536];
    logic [7:0]         scan_stamp;
    int                 hit_inc, free_dec, occ_thr, clr_thr, score_lo, score_hi;

    initial begin
        for (int i = 0; i < 65536; i++) begin
            grid_score[i] = '0;
            grid_visited[i] = 0;
            grid_confirmed[i] = 0;
            grid_stamp[i] = '0;
        end
        scan_stamp = '0;
        hit_inc = 2;
        free_dec = 1;
        occ_thr = 4;
        clr_thr = 0;
        score_lo = -16;
        score_hi = 16;
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic int clamp_score(int v);
        if (v < score_lo) return score_lo;
        if (v > score_hi) return score_hi;
        return v;
    endfunction

    function automatic logic [1:0] cell_state_of(int idx);
        if (!grid_visited[idx]) return ogru_pkg::ST_UNKNOWN;
        return grid_confirmed[idx] ? ogru_pkg::ST_OCCUPIED : ogru_pkg::ST_FREE;
    endfunction

    function automatic int walk_ray(int x0, int y0, int x1, int y1, bit hit, output bit newly);
        int dx, dy, sx, sy, err, e2, x, y, idx, count, s;
        bit last, old_occ;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        sx = (x0 < x1) ? 1 : -1;
        dy = (y1 > y0) ? y0 - y1 : y1 - y0;
        sy = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        x = x0;
        y = y0;
        count = 0;
        newly = 0;
        while (1) begin
            idx = x + y * 256;
            last = (x == x1) && (y == y1);
            old_occ = grid_visited[idx] && grid_confirmed[idx];
            grid_visited[idx] = 1;
            count++;
            if (hit && last) begin
                s = clamp_score(int'(grid_score[idx]) + hit_inc);
                grid_score[idx] = s[15:0];
                if (int'(grid_score[idx]) >= occ_thr) grid_confirmed[idx] = 1;
                newly = !old_occ && grid_confirmed[idx];
            end else begin
                s = clamp_score(int'(grid_score[idx]) - free_dec);
                grid_score[idx] = s[15:0];
                if (grid_confirmed[idx] && int'(grid_score[idx]) <= clr_thr)
                    grid_confirmed[idx] = 0;
            end
            if (last) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y += sy;
            end
        end
        return count;
    endfunction

    function automatic t_ray_word predict_word(logic [1:0] op, int sx, int sy, int ex, int ey);
        t_ray_word w;
        int eidx, n;
        bit nw;
        w = '{1'b0, 1'b0, ogru_pkg::ST_UNKNOWN, 9'd0};
        eidx = ex + ey * 256;
        n = 0;
        nw = 0;
        case (op)
            ogru_pkg::OP_BEGIN: begin
                scan_stamp = scan_stamp + 8'd1;
                if (scan_stamp == 8'd0) begin
                    for (int i = 0; i < 65536; i++) grid_stamp[i] = '0;
                    scan_stamp = 8'd1;
                end
            end
            ogru_pkg::OP_READ: w.state = cell_state_of(sx + sy * 256);
            ogru_pkg::OP_HIT: begin
                if (grid_stamp[eidx] == scan_stamp) begin
                    w.dup = 1'b1;
                end else begin
                    grid_stamp[eidx] = scan_stamp;
                    n = walk_ray(sx, sy, ex, ey, 1, nw);
                end
                w.newly = nw;
                w.touched = (n > 511) ? 9'd511 : n[8:0];
                w.state = cell_state_of(eidx);
            end
            default: begin
                n = walk_ray(sx, sy, ex, ey, 0, nw);
                w.touched = (n > 511) ? 9'd511 : n[8:0];
                w.state = cell_state_of(eidx);
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_ray_word w;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ogru_pkg::REG_HIT_INC:   hit_inc = int'(i_cfg_data[7:0]);
                    ogru_pkg::REG_FREE_DEC:  free_dec = int'(i_cfg_data[7:0]);
                    ogru_pkg::REG_OCC_THR:   occ_thr = int'($signed(i_cfg_data));
                    ogru_pkg::REG_CLR_THR:   clr_thr = int'($signed(i_cfg_data));
                    ogru_pkg::REG_MIN_SCORE: score_lo = int'($signed(i_cfg_data));
                    ogru_pkg::REG_MAX_SCORE: score_hi = int'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    w = words_due.pop_front();
                    if (i_newly_occupied !== w.newly)
                        report_mismatch("newly_occupied", int'(i_newly_occupied),
                                        int'(w.newly));
                    if (i_duplicate_skipped !== w.dup)
                        report_mismatch("duplicate_skipped", int'(i_duplicate_skipped),
                                        int'(w.dup));
                    if (i_cell_state !== w.state)
                        report_mismatch("cell_state", int'(i_cell_state), int'(w.state));
                    if (i_cells_touched !== w.touched)
                        report_mismatch("cells_touched", int'(i_cells_touched),
                                        int'(w.touched));
                end
            end
            if (i_start && !i_busy)
                words_due.insert(words_due.size(),
                                 predict_word(i_op, int'(i_start_x), int'(i_start_y),
                                              int'(i_end_x), int'(i_end_y)));
        end
        o_pending <= words_due.size();
    end

endmodule

// File: tb/sv/occupancy_grid_ray_update_tb.sv
`timescale 1ns / 1ps
// Top of the occupancy grid ray update testbench: clock, reset, stimulus and
// verdict. Depends on ogru_pkg, ogru_ray_checker and the block itself.
module occupancy_grid_ray_update_tb;

    localparam int STALL_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic [1:0]  i_op;
    logic [7:0]  i_start_x, i_start_y, i_end_x, i_end_y;
    logic        o_valid, o_newly_occupied, o_duplicate_skipped;
    logic [1:0]  o_cell_state;
    logic [8:0]  o_cells_touched;
    int          fail_count, words_pending, idle_pct, stall_cycles;
    logic [7:0]  anchor_x, anchor_y;

    occupancy_grid_ray_update u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_op(i_op), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .o_valid(o_valid),
        .o_newly_occupied(o_newly_occupied), .o_duplicate_skipped(o_duplicate_skipped),
        .o_cell_state(o_cell_state), .o_cells_touched(o_cells_touched)
    );

    ogru_ray_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_op(i_op), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_valid(o_valid),
        .i_newly_occupied(o_newly_occupied), .i_duplicate_skipped(o_duplicate_skipped),
        .i_cell_state(o_cell_state), .i_cells_touched(o_cells_touched),
        .o_fail_count(fail_count), .o_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("occupancy_grid_ray_update_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue(logic [1:0] op, logic [7:0] sx, logic [7:0] sy,
                         logic [7:0] ex, logic [7:0] ey);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] hit_inc, logic [15:0] free_dec,
                              logic [15:0] occ_thr, logic [15:0] clr_thr,
                              logic [15:0] lo, logic [15:0] hi);
        logic [15:0] vals [6];
        vals = '{hit_inc, free_dec, occ_thr, clr_thr, lo, hi};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_coord(logic [7:0] anchor);
        case ($urandom_range(9))
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return anchor + 8'($urandom_range(7));
        endcase
    endfunction

    task automatic random_items(int count);
        int r;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            op = (r < 20) ? ogru_pkg::OP_BEGIN : (r < 55) ? ogru_pkg::OP_HIT :
                 (r < 80) ? ogru_pkg::OP_FREE : ogru_pkg::OP_READ;
            if ($urandom_range(99) < 5)
                issue(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                issue(op, pick_coord(anchor_x), pick_coord(anchor_y),
                      pick_coord(anchor_x), pick_coord(anchor_y));
            if (n % 120 == 119) drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_op = ogru_pkg::OP_BEGIN;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        stall_cycles = 0;
        idle_pct = 0;
        anchor_x = 8'd40;
        anchor_y = 8'd40;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(ogru_pkg::OP_HIT, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(ogru_pkg::OP_BEGIN, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(ogru_pkg::OP_HIT, 8'd0, 8'd0, 8'd255, 8'd255);
        issue(ogru_pkg::OP_HIT, 8'd3, 8'd9, 8'd255, 8'd255);
        issue(ogru_pkg::OP_FREE, 8'd255, 8'd0, 8'd0, 8'd255);
        issue(ogru_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(ogru_pkg::OP_READ, 8'd255, 8'd255, 8'd0, 8'd0);
        issue(ogru_pkg::OP_READ, 8'd100, 8'd200, 8'd0, 8'd0);
        for (int i = 0; i < 3; i++) begin
            issue(ogru_pkg::OP_HIT, 8'd10, 8'd10, 8'd10, 8'd10);
            issue(ogru_pkg::OP_BEGIN, 8'd0, 8'd0, 8'd0, 8'd0);
        end
        issue(ogru_pkg::OP_READ, 8'd10, 8'd10, 8'd0, 8'd0);
        for (int i = 0; i < 5; i++) issue(ogru_pkg::OP_FREE, 8'd10, 8'd10, 8'd10, 8'd10);
        issue(ogru_pkg::OP_HIT, 8'd200, 8'd30, 8'd20, 8'd35);
        issue(ogru_pkg::OP_HIT, 8'd50, 8'd250, 8'd52, 8'd5);
        issue(ogru_pkg::OP_FREE, 8'd0, 8'd255, 8'd255, 8'd0);
        issue(ogru_pkg::OP_READ, 8'd255, 8'd0, 8'd0, 8'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_regs(16'd2, 16'd1, 16'd4, 16'd0, 16'hFFF0, 16'd16);
                1: write_regs(16'd255, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
                2: write_regs(16'd0, 16'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
                default: write_regs(16'd7, 16'd3, 16'd10, 16'hFFFB, 16'hFFE0, 16'd24);
            endcase
            idle_pct = (ph == 0) ? 7 : (ph == 1) ? 88 : 0;
            anchor_x = 8'($urandom_range(255));
            anchor_y = 8'($urandom_range(255));
            random_items(350);
            drain();
        end

        if (fail_count == 0) begin
            $display("occupancy_grid_ray_update_tb passed");
        end else begin
            $display("occupancy_grid_ray_update_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ogru_pkg.sv
rtl/core/ogru_ram.sv
rtl/core/ogru_cell_alu.sv
rtl/core/occupancy_grid_ray_update.sv
tb/sv/ogru_ray_checker.sv
tb/sv/occupancy_grid_ray_update_tb.sv
